### hdl/esa_pkg.sv
// esa_pkg: shared types, codes and constants of the expression stack alu
// no dependencies
package esa_pkg;

  localparam int DATA_W = 32;
  localparam int STACK_DEPTH_DEF = 64;
  localparam int DEPTH_W = 7;

  typedef enum logic [3:0] {
    FN_PUSH = 4'd0, FN_POP = 4'd1, FN_ADD = 4'd2, FN_SUB = 4'd3,
    FN_NEG = 4'd4, FN_MUL = 4'd5, FN_DIV = 4'd6, FN_REM = 4'd7,
    FN_AND = 4'd8, FN_OR = 4'd9, FN_XOR = 4'd10, FN_CPL = 4'd11,
    FN_SHR = 4'd12, FN_SHL = 4'd13
  } func_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_OVERFLOW = 2'd1, ST_UNDERFLOW = 2'd2, ST_DIVZERO = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_TOP, S_RD_SEC, S_WAIT_SEC, S_EXEC, S_SERIAL, S_WRITE, S_RD_NEW,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    SER_MUL = 2'd0, SER_DIV = 2'd1, SER_SHR = 2'd2, SER_SHL = 2'd3
  } ser_op_t;

  typedef struct packed {
    logic [3:0]         func;
    logic signed [31:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] top_value;
    logic [1:0]         status;
    logic [6:0]         stack_depth;
  } out_item_t;

  typedef struct packed {
    logic    start;
    ser_op_t op;
    logic    want_rem;
  } ser_ctl_t;

endpackage

### hdl/esa_ram.sv
// esa_ram: generic single-port ram with registered read
// no dependencies
module esa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

### hdl/esa_serial.sv
// esa_serial: bit-serial multiply, divide and shift unit, one bit per cycle
// depends on esa_pkg
module esa_serial (
  input  logic             clk,
  input  logic             rst_n,
  input  esa_pkg::ser_ctl_t ctl,
  input  logic [31:0]      a,
  input  logic [31:0]      b,
  output logic             done,
  output logic [31:0]      result
);
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [31:0] acc_r, acc_nxt;     // product, remainder or shifted value
  logic [31:0] sh_r, sh_nxt;       // multiplier bits or quotient/dividend bits
  logic [31:0] b_r, b_nxt;
  esa_pkg::ser_op_t op_r, op_nxt;
  logic        rem_r, rem_nxt, neg_q_r, neg_q_nxt, neg_r_r, neg_r_nxt;
  logic [32:0] trial;
  logic [31:0] ma, mb, qfix, rfix;

  assign ma = a[31] ? (32'd0 - a) : a;
  assign mb = b[31] ? (32'd0 - b) : b;
  assign trial = {acc_r, sh_r[31]} - {1'b0, b_r};
  assign qfix = neg_q_r ? (32'd0 - sh_r) : sh_r;
  assign rfix = neg_r_r ? (32'd0 - acc_r) : acc_r;

  always_comb begin
    cnt_nxt = cnt_r; busy_nxt = busy_r; acc_nxt = acc_r; sh_nxt = sh_r;
    b_nxt = b_r; op_nxt = op_r; rem_nxt = rem_r;
    neg_q_nxt = neg_q_r; neg_r_nxt = neg_r_r;
    done = 1'b0;
    result = acc_r;
    if (ctl.start) begin
      busy_nxt = 1'b1; cnt_nxt = 6'd32; op_nxt = ctl.op; rem_nxt = ctl.want_rem;
      neg_q_nxt = a[31] ^ b[31]; neg_r_nxt = a[31];
      case (ctl.op)
        esa_pkg::SER_MUL: begin acc_nxt = '0; sh_nxt = b; b_nxt = a; end
        esa_pkg::SER_DIV: begin acc_nxt = '0; sh_nxt = ma; b_nxt = mb; end
        default: begin
          // counts of 32 or more saturate to the full fill
          acc_nxt = a; sh_nxt = '0;
          b_nxt = (b[31:5] != '0) ? 32'd32 : {27'd0, b[4:0]};
        end
      endcase
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 6'd1;
      case (op_r)
        esa_pkg::SER_MUL: begin
          acc_nxt = sh_r[31] ? ({acc_r[30:0], 1'b0} + b_r) : {acc_r[30:0], 1'b0};
          sh_nxt = {sh_r[30:0], 1'b0};
        end
        esa_pkg::SER_DIV: begin
          if (!trial[32]) begin
            acc_nxt = trial[31:0]; sh_nxt = {sh_r[30:0], 1'b1};
          end else begin
            acc_nxt = {acc_r[30:0], sh_r[31]}; sh_nxt = {sh_r[30:0], 1'b0};
          end
        end
        esa_pkg::SER_SHR: begin
          if (b_r[5:0] != '0) begin
            acc_nxt = {acc_r[31], acc_r[31:1]}; b_nxt = b_r - 32'd1;
          end
        end
        default: begin
          if (b_r[5:0] != '0) begin
            acc_nxt = {acc_r[30:0], 1'b0}; b_nxt = b_r - 32'd1;
          end
        end
      endcase
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0; done = 1'b1;
        cnt_nxt = cnt_r; acc_nxt = acc_r; sh_nxt = sh_r; b_nxt = b_r;
        if (op_r == esa_pkg::SER_DIV) begin
          result = rem_r ? rfix : qfix;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt; sh_r <= sh_nxt; b_r <= b_nxt; op_r <= op_nxt;
    rem_r <= rem_nxt; neg_q_r <= neg_q_nxt; neg_r_r <= neg_r_nxt;
  end
endmodule

### hdl/expression_stack_alu.sv
// expression_stack_alu: 32-bit evaluation stack with a bit-serial alu
// depends on esa_pkg, esa_ram, esa_serial
//
//  port      dir  meaning
//  in_*      in   start/busy command, one transaction per start while not busy
//  out_*     out  out_valid strobe, one cycle per transaction, never stalled
//  cfg_*     in   cfg_we/cfg_wdata write the assembly pass bit
//
// the strobe follows S_RD_NEW and S_OUT; errors and unused codes go there from idle,
// push through S_EXEC and S_WRITE, the rest first via S_RD_TOP, S_RD_SEC, S_WAIT_SEC
// (ram read latency); div by zero skips S_WRITE; serial mul/shift/div/rem add S_SERIAL
// synchronous reset empties the stack; stack contents stay undefined until pushed
// the receiver cannot stall; busy covers the whole item and the strobe cycle
module expression_stack_alu #(
  parameter int STACK_DEPTH = esa_pkg::STACK_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  esa_pkg::in_item_t  in_item,
  output logic               out_valid,
  output esa_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int PW = $clog2(STACK_DEPTH + 1);

  esa_pkg::state_t state_r, state_nxt;
  logic [PW-1:0] sp_r, sp_nxt;
  logic          pass_r;
  logic [3:0]    func_r, func_nxt;
  logic [31:0]   pv_r, pv_nxt, b_r, b_nxt, a_r, a_nxt, res_r, res_nxt;
  logic [31:0]   top_r, top_nxt;
  logic [1:0]    st_r, st_nxt;
  logic          popped_r, popped_nxt;
  logic          we;
  logic [AW-1:0] addr;
  logic [31:0]   wdata, rdata;
  esa_pkg::ser_ctl_t ser_ctl;
  logic          ser_done;
  logic [31:0]   ser_res;
  logic          out_valid_r;
  esa_pkg::out_item_t out_r;

  esa_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  esa_serial u_ser (
    .clk(clk), .rst_n(rst_n), .ctl(ser_ctl), .a(a_r), .b(b_r),
    .done(ser_done), .result(ser_res)
  );

  function automatic logic [AW-1:0] idx(input logic [PW-1:0] p, input int unsigned k);
    logic [PW-1:0] d;
    d = p - PW'(k);
    return d[AW-1:0];
  endfunction

  always_comb begin
    state_nxt = state_r; sp_nxt = sp_r; func_nxt = func_r; pv_nxt = pv_r;
    b_nxt = b_r; a_nxt = a_r; res_nxt = res_r; top_nxt = top_r; st_nxt = st_r;
    popped_nxt = popped_r;
    we = 1'b0; addr = idx(sp_r, 1); wdata = res_r;
    ser_ctl = '{start: 1'b0, op: esa_pkg::SER_MUL, want_rem: 1'b0};
    case (state_r)
      esa_pkg::S_IDLE: begin
        if (start && !busy) begin
          func_nxt = in_item.func; pv_nxt = in_item.push_value;
          st_nxt = esa_pkg::ST_OK; popped_nxt = 1'b0;
          state_nxt = esa_pkg::S_EXEC;
          case (in_item.func)
            esa_pkg::FN_PUSH: begin
              if (sp_r == PW'(STACK_DEPTH)) st_nxt = esa_pkg::ST_OVERFLOW;
              else state_nxt = esa_pkg::S_EXEC;
            end
            esa_pkg::FN_POP, esa_pkg::FN_NEG, esa_pkg::FN_CPL: begin
              if (sp_r == '0) st_nxt = esa_pkg::ST_UNDERFLOW;
              else state_nxt = esa_pkg::S_RD_TOP;
            end
            esa_pkg::FN_ADD, esa_pkg::FN_SUB, esa_pkg::FN_MUL, esa_pkg::FN_DIV,
            esa_pkg::FN_REM, esa_pkg::FN_AND, esa_pkg::FN_OR, esa_pkg::FN_XOR,
            esa_pkg::FN_SHR, esa_pkg::FN_SHL: begin
              if (sp_r < PW'(2)) st_nxt = esa_pkg::ST_UNDERFLOW;
              else state_nxt = esa_pkg::S_RD_TOP;
            end
            default: ;
          endcase
          // error or unused code: just read back the current top
          if (st_nxt != esa_pkg::ST_OK || in_item.func > esa_pkg::FN_SHL) begin
            state_nxt = esa_pkg::S_RD_NEW;
          end
        end
      end
      esa_pkg::S_RD_TOP: begin
        addr = idx(sp_r, 1);
        state_nxt = esa_pkg::S_RD_SEC;
      end
      esa_pkg::S_RD_SEC: begin
        addr = idx(sp_r, 2);
        b_nxt = rdata;
        state_nxt = esa_pkg::S_WAIT_SEC;
      end
      esa_pkg::S_WAIT_SEC: begin
        a_nxt = rdata;
        state_nxt = esa_pkg::S_EXEC;
      end
      esa_pkg::S_EXEC: begin
        state_nxt = esa_pkg::S_WRITE;
        res_nxt = a_r;
        case (func_r)
          esa_pkg::FN_PUSH: res_nxt = pv_r;
          esa_pkg::FN_POP: begin top_nxt = b_r; popped_nxt = 1'b1; end
          esa_pkg::FN_NEG: res_nxt = 32'd0 - b_r;
          esa_pkg::FN_CPL: res_nxt = ~b_r;
          esa_pkg::FN_ADD: res_nxt = a_r + b_r;
          esa_pkg::FN_SUB: res_nxt = a_r - b_r;
          esa_pkg::FN_AND: res_nxt = a_r & b_r;
          esa_pkg::FN_OR:  res_nxt = a_r | b_r;
          esa_pkg::FN_XOR: res_nxt = a_r ^ b_r;
          esa_pkg::FN_MUL: begin
            ser_ctl = '{start: 1'b1, op: esa_pkg::SER_MUL, want_rem: 1'b0};
            state_nxt = esa_pkg::S_SERIAL;
          end
          esa_pkg::FN_SHR: begin
            ser_ctl = '{start: 1'b1, op: esa_pkg::SER_SHR, want_rem: 1'b0};
            state_nxt = esa_pkg::S_SERIAL;
          end
          esa_pkg::FN_SHL: begin
            ser_ctl = '{start: 1'b1, op: esa_pkg::SER_SHL, want_rem: 1'b0};
            state_nxt = esa_pkg::S_SERIAL;
          end
          esa_pkg::FN_DIV, esa_pkg::FN_REM: begin
            if (pass_r) begin
              if (b_r == '0) begin
                st_nxt = esa_pkg::ST_DIVZERO;
                state_nxt = esa_pkg::S_RD_NEW;
              end else begin
                ser_ctl = '{start: 1'b1, op: esa_pkg::SER_DIV,
                            want_rem: (func_r == esa_pkg::FN_REM)};
                state_nxt = esa_pkg::S_SERIAL;
              end
            end
          end
          default: ;
        endcase
      end
      esa_pkg::S_SERIAL: begin
        if (ser_done) begin
          res_nxt = ser_res;
          state_nxt = esa_pkg::S_WRITE;
        end
      end
      esa_pkg::S_WRITE: begin
        state_nxt = esa_pkg::S_RD_NEW;
        case (func_r)
          esa_pkg::FN_PUSH: begin
            we = 1'b1; addr = sp_r[AW-1:0]; sp_nxt = sp_r + PW'(1);
          end
          esa_pkg::FN_POP: sp_nxt = sp_r - PW'(1);
          esa_pkg::FN_NEG, esa_pkg::FN_CPL: begin
            we = 1'b1; addr = idx(sp_r, 1);
          end
          default: begin
            we = 1'b1; addr = idx(sp_r, 2); sp_nxt = sp_r - PW'(1);
          end
        endcase
      end
      esa_pkg::S_RD_NEW: begin
        addr = idx(sp_r, 1);
        state_nxt = esa_pkg::S_OUT;
      end
      esa_pkg::S_OUT: begin
        if (!popped_r) top_nxt = (sp_r == '0) ? 32'd0 : rdata;
        state_nxt = esa_pkg::S_IDLE;
      end
      default: state_nxt = esa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= esa_pkg::S_IDLE;
      sp_r <= '0;
      pass_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sp_r <= sp_nxt;
      if (cfg_we) pass_r <= cfg_wdata;
      out_valid_r <= (state_r == esa_pkg::S_OUT);
    end
    func_r <= func_nxt; pv_r <= pv_nxt; b_r <= b_nxt; a_r <= a_nxt;
    res_r <= res_nxt; top_r <= top_nxt; st_r <= st_nxt; popped_r <= popped_nxt;
    out_r.top_value <= top_nxt;
    out_r.status <= st_r;
    out_r.stack_depth <= 7'(sp_r);
  end

  assign busy = (state_r != esa_pkg::S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_item = out_r;

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= PW'(STACK_DEPTH)) else $error("stack pointer beyond depth");
  a_one_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held");
  a_err_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == esa_pkg::S_OUT && st_r != esa_pkg::ST_OK) |-> $stable(sp_r))
    else $error("error changed stack");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("not busy after start");
endmodule

### tb/tb_expression_stack_alu.sv
// tb_expression_stack_alu: self-checking testbench for the expression stack alu
// depends on esa_pkg and expression_stack_alu; holds its own stack predictor
`timescale 1ns / 100ps

class stack_scoreboard;
  logic [31:0] entries [64];
  int unsigned depth;
  logic first_pass_n;
  esa_pkg::out_item_t pending [$];
  int errors;
  int checked;

  function void clear();
    depth = 0;
    first_pass_n = 1'b0;
    pending.delete();
    errors = 0;
    checked = 0;
  endfunction

  function logic [31:0] signed_div(logic [31:0] a, logic [31:0] b, bit want_rem);
    logic [31:0] ma, mb, q, r;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    r = ma % mb;
    if (want_rem) return a[31] ? -r : r;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  // apply one accepted transaction to the model stack and queue its result
  function void note_command(esa_pkg::in_item_t it);
    esa_pkg::out_item_t res;
    logic [31:0] a, b, r;
    bit popped, ok;
    popped = 0;
    ok = 1;
    res = '0;
    res.status = esa_pkg::ST_OK;
    case (it.func)
      esa_pkg::FN_PUSH:
        if (depth >= 64) res.status = esa_pkg::ST_OVERFLOW;
        else begin
          entries[depth] = it.push_value;
          depth++;
        end
      esa_pkg::FN_POP:
        if (depth < 1) res.status = esa_pkg::ST_UNDERFLOW;
        else begin
          depth--;
          res.top_value = entries[depth];
          popped = 1;
        end
      esa_pkg::FN_NEG, esa_pkg::FN_CPL:
        if (depth < 1) res.status = esa_pkg::ST_UNDERFLOW;
        else if (it.func == esa_pkg::FN_NEG) entries[depth-1] = -entries[depth-1];
        else entries[depth-1] = ~entries[depth-1];
      4'd14, 4'd15: ;
      default:
        if (depth < 2) res.status = esa_pkg::ST_UNDERFLOW;
        else begin
          a = entries[depth-2];
          b = entries[depth-1];
          r = a;
          case (it.func)
            esa_pkg::FN_ADD: r = a + b;
            esa_pkg::FN_SUB: r = a - b;
            esa_pkg::FN_MUL: r = a * b;
            esa_pkg::FN_DIV, esa_pkg::FN_REM:
              if (first_pass_n) begin
                if (b == 0) begin
                  res.status = esa_pkg::ST_DIVZERO;
                  ok = 0;
                end else r = signed_div(a, b, it.func == esa_pkg::FN_REM);
              end
            esa_pkg::FN_AND: r = a & b;
            esa_pkg::FN_OR: r = a | b;
            esa_pkg::FN_XOR: r = a ^ b;
            esa_pkg::FN_SHR: r = (b >= 32) ? {32{a[31]}} : 32'($signed(a) >>> b[4:0]);
            default: r = (b >= 32) ? 32'd0 : a << b[4:0];
          endcase
          if (ok) begin
            depth--;
            entries[depth-1] = r;
          end
        end
    endcase
    if (!popped) res.top_value = (depth > 0) ? entries[depth-1] : 32'd0;
    res.stack_depth = 7'(depth);
    pending.push_back(res);
  endfunction

  task report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0h expected %0h", what, got, want);
  endtask

  task check_result(esa_pkg::out_item_t got);
    esa_pkg::out_item_t want;
    if (pending.size() == 0) begin
      report("unexpected result", got.top_value, '0);
      return;
    end
    want = pending.pop_front();
    checked++;
    if (got.top_value !== want.top_value) report("top_value", got.top_value, want.top_value);
    if (got.status !== want.status)
      report("status", 32'(got.status), 32'(want.status));
    if (got.stack_depth !== want.stack_depth)
      report("stack_depth", 32'(got.stack_depth), 32'(want.stack_depth));
  endtask
endclass

module tb_expression_stack_alu;
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  esa_pkg::in_item_t in_item = '0;
  logic out_valid;
  esa_pkg::out_item_t out_item;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  int unsigned cycles = 0;
  int unsigned sent = 0;
  stack_scoreboard calc_model;

  localparam int unsigned CYCLE_LIMIT = 400000;

  expression_stack_alu u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid) calc_model.check_result(out_item);
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // start stays high after the accept while the block is busy; the next call
  // lowers it for a random gap or drives its own item, or drain() lowers it
  task automatic send_command(logic [3:0] fn, logic [31:0] value);
    esa_pkg::in_item_t it;
    int unsigned gap;
    it.func = fn;
    it.push_value = value;
    gap = $urandom_range(0, 10);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    calc_model.note_command(it);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (calc_model.pending.size() != 0) @(negedge clk);
    repeat (45) @(negedge clk);
  endtask

  // only written while idle
  task automatic set_pass(logic value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    calc_model.first_pass_n = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'd0;
      4: return $urandom_range(0, 40);
      5: return -$urandom_range(0, 40);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(int count);
    int fill;
    logic [3:0] fn;
    for (int i = 0; i < count; i++) begin
      fill = calc_model.depth;
      // mostly keep the stack between a couple and a few dozen entries
      if (fill < 2 || ($urandom_range(0, 2) == 0 && fill < 60)) fn = esa_pkg::FN_PUSH;
      else if ($urandom_range(0, 20) == 0) fn = 4'($urandom_range(14, 15));
      else fn = 4'($urandom_range(1, 13));
      send_command(fn, pick_value());
    end
  endtask

  initial begin
    calc_model = new();
    calc_model.clear();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // directed: underflow on empty, first-pass div/rem, divide by zero, corners
    send_command(esa_pkg::FN_POP, 0);
    send_command(esa_pkg::FN_ADD, 0);
    send_command(esa_pkg::FN_NEG, 0);
    send_command(esa_pkg::FN_PUSH, 32'h8000_0000);
    send_command(esa_pkg::FN_PUSH, 32'd0);
    send_command(esa_pkg::FN_DIV, 0);
    send_command(esa_pkg::FN_PUSH, 32'd0);
    send_command(esa_pkg::FN_REM, 0);
    set_pass(1'b1);
    send_command(esa_pkg::FN_PUSH, 32'hffff_ffff);
    send_command(esa_pkg::FN_DIV, 0);
    send_command(esa_pkg::FN_PUSH, 32'd0);
    send_command(esa_pkg::FN_REM, 0);
    send_command(esa_pkg::FN_POP, 0);
    send_command(esa_pkg::FN_PUSH, 32'd40);
    send_command(esa_pkg::FN_SHR, 0);
    send_command(esa_pkg::FN_PUSH, 32'hffff_ffff);
    send_command(esa_pkg::FN_SHL, 0);
    send_command(4'd15, 0);
    send_command(esa_pkg::FN_CPL, 0);
    for (int i = 0; i < 64; i++) send_command(esa_pkg::FN_PUSH, $urandom);
    send_command(esa_pkg::FN_PUSH, 32'h7fff_ffff);
    for (int i = 0; i < 64; i++) send_command(esa_pkg::FN_POP, 0);
    random_phase(500);
    drain();
    set_pass(1'b0);
    random_phase(300);
    set_pass(1'b1);
    random_phase(500);
    drain();
    $display("sent %0d transactions, checked %0d results over both pass settings",
             sent, calc_model.checked);
    if (calc_model.errors == 0 && calc_model.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
